/* hdl/running_median_abs_deviation_top_defines.svh */
// Assertion macros used by the checks in the top module
`ifndef RUNNING_MEDIAN_ABS_DEVIATION_TOP_DEFINES_SVH
`define RUNNING_MEDIAN_ABS_DEVIATION_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define RMAD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent
`define RMAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rmad_pkg.sv */
package rmad_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CountW = $clog2(Capacity + 1);
  localparam int unsigned ValueW = 32;
  localparam int unsigned CostW = 44;
  localparam int unsigned AccW = 64;
  localparam int unsigned OffSumW = 42;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture input item
    logic mem_re;      // read store at rd_addr
    logic [AddrW-1:0] rd_addr;
    logic mem_we;      // write store at wr_addr
    logic [AddrW-1:0] wr_addr;
    logic wr_sel_new;  // write the new value instead of the read data
    logic cmp_en;      // compare read data with new value
    logic take_med;    // latch read data as median
    logic acc_clr;
    logic acc_en;      // add |median - read data|
    logic ins_done;    // count++ and offset sum update
    logic res_load;
    logic [1:0] res_status;
    logic res_zero;
  } rmad_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic func;
    logic [CountW-1:0] count;
    logic greater;     // last compared entry is greater than new value
  } rmad_stat_t;

endpackage

/* hdl/rmad_in_if.sv */
interface rmad_in_if;
  import rmad_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic signed [ValueW-1:0] value;
  logic signed [ValueW-1:0] offset;
  modport source(output valid, func, value, offset, input ready);
  modport sink(input valid, func, value, offset, output ready);
endinterface

/* hdl/rmad_out_if.sv */
interface rmad_out_if;
  import rmad_pkg::*;
  logic valid;
  logic ready;
  logic signed [ValueW-1:0] median;
  logic signed [CostW-1:0] min_cost;
  logic [1:0] status;
  modport source(output valid, median, min_cost, status, input ready);
  modport sink(input valid, median, min_cost, status, output ready);
endinterface

/* hdl/rmad_ram.sv */
module rmad_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // One write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* hdl/rmad_datapath.sv */
module rmad_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmad_pkg::rmad_cmd_t cmd_i,
  output rmad_pkg::rmad_stat_t stat_o,
  rmad_in_if.sink             in_if,
  rmad_out_if.source          out_if
);
  import rmad_pkg::*;

  logic func_q;
  logic signed [ValueW-1:0] val_q, off_q, med_q;
  logic [CountW-1:0] count_q;
  logic signed [OffSumW-1:0] offsum_q;
  logic signed [AccW-1:0] acc_q;
  logic [ValueW-1:0] rdata;
  logic signed [ValueW:0] diff;
  logic [ValueW:0] absd;
  logic signed [AccW-1:0] total;

  rmad_ram #(.Width(ValueW), .Depth(Capacity)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .waddr_i(cmd_i.wr_addr),
    .wdata_i(cmd_i.wr_sel_new ? val_q : rdata),
    .re_i   (cmd_i.mem_re),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  assign diff = {med_q[ValueW-1], med_q} - {rdata[ValueW-1], rdata};
  assign absd = diff[ValueW] ? (ValueW+1)'(0) - diff : diff;
  assign total = acc_q + AccW'(offsum_q);

  assign stat_o.func = func_q;
  assign stat_o.count = count_q;
  assign stat_o.greater = $signed(rdata) > val_q;

  // Item capture and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      offsum_q <= '0;
    end else if (cmd_i.ins_done) begin
      count_q <= count_q + 1'b1;
      offsum_q <= offsum_q + OffSumW'(off_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_if.func;
      val_q <= in_if.value;
      off_q <= in_if.offset;
    end
    if (cmd_i.take_med) begin
      med_q <= $signed(rdata);
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + AccW'(absd);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_if.status <= cmd_i.res_status;
      out_if.median <= cmd_i.res_zero ? '0 : med_q;
      out_if.min_cost <= cmd_i.res_zero ? '0 : total[CostW-1:0];
    end
  end
endmodule

/* hdl/rmad_ctrl.sv */
module rmad_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rmad_pkg::rmad_stat_t stat_i,
  output rmad_pkg::rmad_cmd_t  cmd_o
);
  import rmad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SHIFT, S_MED, S_SUM, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic pend_q, pend_d;   // a read is in flight for entry idx_q
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  // Insert walks from the top down: move entries greater than the value up
  // one place, then drop the value into the gap. Query reads the median
  // entry, then every entry once, accumulating the absolute deviation.
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    pend_d = pend_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_zero = 1'b1;
        cmd_o.acc_clr = 1'b1;
        if (stat_i.func == FuncInsert) begin
          if (stat_i.count == CountW'(Capacity)) begin
            cmd_o.res_status = StatusFull;
            out_valid_d = 1'b1;
            state_d = S_IDLE;
          end else if (stat_i.count == '0) begin
            cmd_o.mem_we = 1'b1;
            cmd_o.wr_addr = '0;
            cmd_o.wr_sel_new = 1'b1;
            cmd_o.ins_done = 1'b1;
            cmd_o.res_status = StatusOk;
            out_valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.mem_re = 1'b1;
            cmd_o.rd_addr = AddrW'(stat_i.count - 1'b1);
            idx_d = stat_i.count - 1'b1;
            state_d = S_SHIFT;
          end
        end else if (stat_i.count == '0) begin
          cmd_o.res_status = StatusEmpty;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.mem_re = 1'b1;
          cmd_o.rd_addr = AddrW'(((stat_i.count + 1'b1) >> 1) - 1'b1);
          state_d = S_MED;
        end
      end
      S_SHIFT: begin
        // rdata holds entry idx_q
        if (stat_i.greater) begin
          cmd_o.mem_we = 1'b1;
          cmd_o.wr_addr = AddrW'(idx_q + 1'b1);
          if (idx_q == '0) begin
            state_d = S_DONE;
          end else begin
            cmd_o.mem_re = 1'b1;
            cmd_o.rd_addr = AddrW'(idx_q - 1'b1);
            idx_d = idx_q - 1'b1;
          end
        end else begin
          cmd_o.mem_we = 1'b1;
          cmd_o.wr_addr = AddrW'(idx_q + 1'b1);
          cmd_o.wr_sel_new = 1'b1;
          cmd_o.ins_done = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_zero = 1'b1;
          cmd_o.res_status = StatusOk;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_addr = '0;
        cmd_o.wr_sel_new = 1'b1;
        cmd_o.ins_done = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_zero = 1'b1;
        cmd_o.res_status = StatusOk;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_MED: begin
        cmd_o.take_med = 1'b1;
        cmd_o.mem_re = 1'b1;
        cmd_o.rd_addr = '0;
        idx_d = '0;
        pend_d = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        if (pend_q) begin
          cmd_o.acc_en = 1'b1;
          if (idx_q + 1'b1 == stat_i.count) begin
            pend_d = 1'b0;
          end else begin
            cmd_o.mem_re = 1'b1;
            cmd_o.rd_addr = AddrW'(idx_q + 1'b1);
            idx_d = idx_q + 1'b1;
          end
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_status = StatusOk;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

/* hdl/running_median_abs_deviation_top.sv */
// Running lower median with sum of absolute deviations.
// in_if (sink): func 0 inserts value and adds offset to the offset sum,
//   func 1 queries. out_if (source): one item per input item with median,
//   min_cost (44-bit wrapped) and status (0 ok, 1 empty query, 2 full insert).
// Both channels use valid/ready; an item moves when both are high.
// The store is a 1024 x 32 single-port-write, registered-read RAM kept
// sorted; one item is processed at a time.
// Insert into a non-empty store: each stored entry greater than the value
//   shifts up one place per cycle, one RAM read/write each, then the value drops into the gap.
// Query: the median entry is read, then one RAM read per stored entry.
// Full insert, empty query and insert into an empty store finish in the dispatch state.
// The result stays in the output register until taken; a new item is
//   accepted only once it has been taken.
// Reset clears the entry count and offset sum; the RAM needs no clearing
//   since only the first count entries are read.
`include "running_median_abs_deviation_top_defines.svh"
module running_median_abs_deviation_top (
  input logic        clk_i,
  input logic        rst_ni,
  rmad_in_if.sink    in_if,
  rmad_out_if.source out_if
);
  import rmad_pkg::*;

  rmad_cmd_t cmd;
  rmad_stat_t stat;

  rmad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rmad_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .stat_o(stat),
    .in_if (in_if),
    .out_if(out_if)
  );

  `RMAD_ASSERT_IMPL(a_no_accept_while_busy, out_if.valid, !in_if.ready, "accept while result pending")
  `RMAD_ASSERT_IMPL(a_count_bound, 1'b1, stat.count <= CountW'(Capacity), "count over capacity")
  `RMAD_ASSERT_NEXT(a_full_flag, cmd.res_load && cmd.res_status == StatusFull, out_if.valid && out_if.status == StatusFull, "full status lost")
endmodule

/* tb/rmad_tb_pkg.sv */
package rmad_tb_pkg;
  import rmad_pkg::*;

  // One request to the block
  typedef struct packed {
    logic func;
    logic signed [ValueW-1:0] value;
    logic signed [ValueW-1:0] offset;
  } req_item_t;

  // One answer from the block
  typedef struct packed {
    logic signed [ValueW-1:0] median;
    logic signed [CostW-1:0] min_cost;
    logic [1:0] status;
  } ans_item_t;
endpackage

/* tb/tb.sv */
module tb;
  import rmad_pkg::*;
  import rmad_tb_pkg::*;

  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned RandItems = 562;

  logic clk_i;
  logic rst_ni;
  bit failed;
  bit stim_done;
  bit hold_off;
  int unsigned idle_cycles;

  rmad_in_if in_if ();
  rmad_out_if out_if ();

  running_median_abs_deviation_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: sorted multiset and offset sum
  longint signed sorted_vals[$];
  longint signed offset_total;
  req_item_t pending_reqs[$];
  ans_item_t expected_answers[$];

  function automatic ans_item_t predict_answer(req_item_t r);
    ans_item_t a;
    int pos;
    longint signed med;
    longint signed cost;
    a = '0;
    if (r.func == FuncInsert) begin
      if (sorted_vals.size() >= Capacity) begin
        a.status = StatusFull;
      end else begin
        pos = 0;
        while (pos < sorted_vals.size() && sorted_vals[pos] <= longint'(r.value)) pos++;
        sorted_vals.insert(pos, longint'(r.value));
        offset_total += longint'(r.offset);
        a.status = StatusOk;
      end
    end else if (sorted_vals.size() == 0) begin
      a.status = StatusEmpty;
    end else begin
      med = sorted_vals[(sorted_vals.size() + 1) / 2 - 1];
      cost = offset_total;
      foreach (sorted_vals[i])
        cost += (med >= sorted_vals[i]) ? med - sorted_vals[i] : sorted_vals[i] - med;
      a.median = med[ValueW-1:0];
      a.min_cost = cost[CostW-1:0];
      a.status = StatusOk;
    end
    return a;
  endfunction

  // Gap length: mostly short, sometimes long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_item_t rand_item(bit query);
    req_item_t r;
    int unsigned k;
    r.func = query ? FuncQuery : FuncInsert;
    k = $urandom_range(0, 9);
    // Narrow values give duplicates, wide ones hit every bit
    if (k < 4) r.value = $signed($urandom_range(0, 20)) - 10;
    else r.value = $urandom;
    r.offset = $urandom;
    return r;
  endfunction

  // Stimulus
  initial begin
    in_if.valid = 1'b0;
    in_if.func = FuncInsert;
    in_if.value = '0;
    in_if.offset = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    offset_total = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty query, extremes, duplicates
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});
    pending_reqs.push_back('{FuncInsert, 32'h7fffffff, 32'h7fffffff});
    pending_reqs.push_back('{FuncQuery, 32'hffffffff, 32'hffffffff});
    pending_reqs.push_back('{FuncInsert, 32'h80000000, 32'h80000000});
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});
    pending_reqs.push_back('{FuncInsert, 32'sd0, -32'sd1});
    pending_reqs.push_back('{FuncInsert, 32'sd0, 32'sd0});
    pending_reqs.push_back('{FuncInsert, 32'h7fffffff, 32'h7fffffff});
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});
    pending_reqs.push_back('{FuncInsert, 32'h80000000, 32'h80000000});
    pending_reqs.push_back('{FuncInsert, -32'sd5, 32'sd3});
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});
    pending_reqs.push_back('{FuncInsert, -32'sd5, 32'sd3});
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});

    // Random mix of inserts and queries
    for (int i = 0; i < RandItems; i++)
      pending_reqs.push_back(rand_item($urandom_range(0, 2) == 0));

    // Closing extremes and queries
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});
    pending_reqs.push_back('{FuncInsert, 32'sd1, 32'sd1});
    pending_reqs.push_back('{FuncInsert, 32'h80000000, 32'h7fffffff});
    pending_reqs.push_back('{FuncQuery, 32'sd0, 32'sd0});
    stim_done = 1'b1;
  end

  // Driver
  int unsigned send_gap;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_answers.push_back(predict_answer(
          '{in_if.func, in_if.value, in_if.offset}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_item_t r;
          r = pending_reqs.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= r.func;
          in_if.value <= r.value;
          in_if.offset <= r.offset;
          send_gap <= pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, early in the random part
  int unsigned hold_count;
  always @(posedge clk_i) begin
    if (rst_ni && !hold_off && hold_count == 0 && expected_answers.size() > 0 &&
        pending_reqs.size() < RandItems - 40 && pending_reqs.size() > 40) begin
      hold_off <= 1'b1;
      hold_count <= 1;
    end else if (hold_off) begin
      if (hold_count >= 300) hold_off <= 1'b0;
      hold_count <= hold_count + 1;
    end
  end

  // Monitor and receiver stalls
  int unsigned recv_gap;
  always @(posedge clk_i) begin
    ans_item_t exp_a;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected answer: median %0d", out_if.median);
          failed <= 1'b1;
        end else begin
          exp_a = expected_answers.pop_front();
          if (out_if.median !== exp_a.median) begin
            $error("median: expected %0d actual %0d", exp_a.median, out_if.median);
            failed <= 1'b1;
          end
          if (out_if.min_cost !== exp_a.min_cost) begin
            $error("min_cost: expected %0d actual %0d", exp_a.min_cost, out_if.min_cost);
            failed <= 1'b1;
          end
          if (out_if.status !== exp_a.status) begin
            $error("status: expected %0d actual %0d", exp_a.status, out_if.status);
            failed <= 1'b1;
          end
        end
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !in_if.valid && expected_answers.size() == 0);
    repeat (1100) @(posedge clk_i);
    if (!failed && expected_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
